/* rtl/key_hold_state_tracker_core_macros.svh */
// Assertion macros used by the checker file.
`ifndef KEY_HOLD_STATE_TRACKER_CORE_MACROS_SVH
`define KEY_HOLD_STATE_TRACKER_CORE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define KHST_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("key hold tracker check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define KHST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("key hold tracker check failed");

`endif

/* rtl/khst_pkg.sv */
package khst_pkg;

  localparam int NUM_KEYS = 256;
  localparam int KEY_W = $clog2(NUM_KEYS);
  localparam int CNT_W = $clog2(NUM_KEYS + 1);
  localparam int TIME_W = 16;
  localparam int CODE_W = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_THRESHOLD = 1'b1;

  typedef enum logic [1:0] {
    OP_DOWN  = 2'd0,
    OP_UP    = 2'd1,
    OP_TICK  = 2'd2,
    OP_QUERY = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KS_UP   = 2'd0,
    KS_DOWN = 2'd1,
    KS_HELD = 2'd2
  } key_status_t;

  typedef struct packed {
    key_status_t       st;
    logic [TIME_W-1:0] timer;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_WALK,
    S_RD,
    S_MOD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic latch;
    logic acc_upd;
    logic walk_clr;
    logic walk;
    logic rd_key;
    logic modify;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    opcode_t in_op;
    logic    acc_pass;
    logic    walk_done;
    logic    out_free;
  } dp_sts_t;

endpackage

/* rtl/khst_ram.sv */
module khst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/khst_ctrl.sv */
module khst_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  khst_pkg::dp_sts_t   sts,
  output khst_pkg::ctrl_cmd_t cmd
);

  khst_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= khst_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      khst_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          case (sts.in_op)
            khst_pkg::OP_DOWN:  state_nxt = khst_pkg::S_RD;
            khst_pkg::OP_UP:    state_nxt = khst_pkg::S_MOD;
            khst_pkg::OP_TICK:  state_nxt = khst_pkg::S_TICK;
            khst_pkg::OP_QUERY: state_nxt = khst_pkg::S_RD;
            default:            state_nxt = khst_pkg::S_RD;
          endcase
        end
      end
      khst_pkg::S_TICK: begin
        cmd.acc_upd = 1'b1;
        if (sts.acc_pass) begin
          cmd.walk_clr = 1'b1;
          state_nxt = khst_pkg::S_WALK;
        end else begin
          state_nxt = khst_pkg::S_RD;
        end
      end
      khst_pkg::S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) begin
          state_nxt = khst_pkg::S_RD;
        end
      end
      khst_pkg::S_RD: begin
        cmd.rd_key = 1'b1;
        state_nxt = khst_pkg::S_MOD;
      end
      khst_pkg::S_MOD: begin
        cmd.modify = 1'b1;
        state_nxt = khst_pkg::S_OUT;
      end
      khst_pkg::S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt = khst_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = khst_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/khst_dp.sv */
module khst_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [1:0]                    in_opcode,
  input  logic [khst_pkg::CODE_W-1:0]   in_key_code,
  input  logic [khst_pkg::TIME_W-1:0]   in_elapsed_time,
  input  logic                          cfg_we,
  input  logic [khst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [khst_pkg::TIME_W-1:0]   cfg_wdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_handled,
  output logic                          out_is_down,
  output logic                          out_is_up,
  output logic                          out_is_held,
  input  khst_pkg::ctrl_cmd_t           cmd,
  output khst_pkg::dp_sts_t             sts
);

  function automatic logic [khst_pkg::TIME_W-1:0] sat_add(
    input logic [khst_pkg::TIME_W-1:0] a,
    input logic [khst_pkg::TIME_W-1:0] b
  );
    logic [khst_pkg::TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[khst_pkg::TIME_W] ? '1 : s[khst_pkg::TIME_W-1:0];
  endfunction

  khst_pkg::opcode_t                 op_r;
  logic [khst_pkg::CODE_W-1:0]       key_r;
  logic [khst_pkg::TIME_W-1:0]       dt_r;
  logic [khst_pkg::TIME_W-1:0]       period_r, period_nxt;
  logic [khst_pkg::TIME_W-1:0]       thresh_r, thresh_nxt;
  logic [khst_pkg::TIME_W-1:0]       acc_r, acc_nxt;
  logic [khst_pkg::TIME_W-1:0]       acc_sum;
  logic [khst_pkg::NUM_KEYS-1:0]     vld_r, vld_nxt;
  logic [khst_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                              pend_r, pend_nxt;
  logic [khst_pkg::KEY_W-1:0]        rd_addr_r, rd_addr_nxt;
  khst_pkg::key_status_t             res_st_r, res_st_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic                              out_handled_r, out_is_down_r, out_is_up_r, out_is_held_r;

  logic                              key_ok;
  logic [khst_pkg::KEY_W-1:0]        key_idx;
  logic                              cnt_end;
  logic                              ram_we, ram_re;
  logic [khst_pkg::KEY_W-1:0]        ram_waddr, ram_raddr;
  logic [khst_pkg::ENTRY_W-1:0]      ram_rdata;
  khst_pkg::entry_t                  ram_wdata;
  khst_pkg::entry_t                  ent;
  logic [khst_pkg::TIME_W-1:0]       new_timer;

  khst_ram #(
    .WIDTH (khst_pkg::ENTRY_W),
    .DEPTH (khst_pkg::NUM_KEYS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign key_ok = (int'(key_r) < khst_pkg::NUM_KEYS);
  assign key_idx = khst_pkg::KEY_W'(key_r);
  assign cnt_end = (cnt_r == khst_pkg::CNT_W'(khst_pkg::NUM_KEYS));
  assign acc_sum = sat_add(acc_r, dt_r);
  assign ent = vld_r[rd_addr_r] ? khst_pkg::entry_t'(ram_rdata)
                                : khst_pkg::entry_t'{st: khst_pkg::KS_UP, timer: '0};
  assign new_timer = sat_add(ent.timer, dt_r);

  assign sts.in_op = khst_pkg::opcode_t'(in_opcode);
  assign sts.acc_pass = (acc_sum > period_r);
  assign sts.walk_done = cnt_end;
  assign sts.out_free = !out_valid_r || out_ready;

  always_comb begin
    period_nxt = period_r;
    thresh_nxt = thresh_r;
    if (cfg_we) begin
      case (cfg_index)
        khst_pkg::CFG_UPDATE_PERIOD:  period_nxt = cfg_wdata;
        khst_pkg::CFG_HOLD_THRESHOLD: thresh_nxt = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    pend_nxt = pend_r;
    rd_addr_nxt = rd_addr_r;
    res_st_nxt = res_st_r;
    ram_we = 1'b0;
    ram_re = 1'b0;
    ram_waddr = rd_addr_r;
    ram_raddr = key_idx;
    ram_wdata = ent;

    if (cmd.acc_upd) begin
      acc_nxt = sts.acc_pass ? '0 : acc_sum;
    end
    if (cmd.walk_clr) begin
      cnt_nxt = '0;
      pend_nxt = 1'b0;
    end

    if (cmd.walk) begin
      if (!cnt_end) begin
        ram_re = 1'b1;
        ram_raddr = cnt_r[khst_pkg::KEY_W-1:0];
        rd_addr_nxt = cnt_r[khst_pkg::KEY_W-1:0];
        cnt_nxt = cnt_r + 1'b1;
        pend_nxt = 1'b1;
      end else begin
        pend_nxt = 1'b0;
      end
      if (pend_r && ent.st == khst_pkg::KS_DOWN) begin
        ram_we = 1'b1;
        ram_waddr = rd_addr_r;
        ram_wdata.timer = new_timer;
        ram_wdata.st = (new_timer > thresh_r) ? khst_pkg::KS_HELD : khst_pkg::KS_DOWN;
      end
    end

    if (cmd.rd_key) begin
      ram_re = 1'b1;
      ram_raddr = key_idx;
      rd_addr_nxt = key_idx;
    end

    if (cmd.modify) begin
      ram_waddr = key_idx;
      case (op_r)
        khst_pkg::OP_DOWN: begin
          ram_we = key_ok;
          ram_wdata.st = khst_pkg::KS_DOWN;
          ram_wdata.timer = ent.timer;
          res_st_nxt = key_ok ? khst_pkg::KS_DOWN : khst_pkg::KS_UP;
        end
        khst_pkg::OP_UP: begin
          ram_we = key_ok;
          ram_wdata.st = khst_pkg::KS_UP;
          ram_wdata.timer = '0;
          res_st_nxt = khst_pkg::KS_UP;
        end
        default: begin
          res_st_nxt = key_ok ? ent.st : khst_pkg::KS_UP;
        end
      endcase
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (ram_we) begin
      vld_nxt[ram_waddr] = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= '0;
      thresh_r <= '0;
      acc_r <= '0;
      vld_r <= '0;
      cnt_r <= '0;
      pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      period_r <= period_nxt;
      thresh_r <= thresh_nxt;
      acc_r <= acc_nxt;
      vld_r <= vld_nxt;
      cnt_r <= cnt_nxt;
      pend_r <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r <= khst_pkg::opcode_t'(in_opcode);
      key_r <= in_key_code;
      dt_r <= in_elapsed_time;
    end
    rd_addr_r <= rd_addr_nxt;
    res_st_r <= res_st_nxt;
    if (cmd.load_out) begin
      out_handled_r <= (op_r == khst_pkg::OP_DOWN) || (op_r == khst_pkg::OP_UP);
      out_is_down_r <= (res_st_r == khst_pkg::KS_DOWN) || (res_st_r == khst_pkg::KS_HELD);
      out_is_up_r <= (res_st_r == khst_pkg::KS_UP);
      out_is_held_r <= (res_st_r == khst_pkg::KS_HELD);
    end
  end

  assign out_valid = out_valid_r;
  assign out_handled = out_handled_r;
  assign out_is_down = out_is_down_r;
  assign out_is_up = out_is_up_r;
  assign out_is_held = out_is_held_r;

endmodule

/* rtl/key_hold_state_tracker_core.sv */
// Tracks the up, down and held status and a hold timer for each key.
// Requests arrive on the in_ channel (valid/ready) with an opcode, a key code
// and an elapsed time; each request returns one result on the out_ channel
// with the handled flag and the addressed key's down, up and held flags.
// The user must write registers update_period and hold_threshold through cfg_
// only while no request is in flight; the block itself does not enforce it.
// The block works on one request at a time. After acceptance, key up goes
// through S_MOD and S_OUT; key down and query through S_RD, S_MOD and S_OUT;
// a tick first visits S_TICK and, if it passes the update period, S_WALK
// before S_RD. The next request is taken in the cycle the result appears.
// A passing tick walks the key RAM one entry a cycle through its one read
// port and one write port.
// Reset clears all key status valid bits, so every key reads as up with a
// zero timer; there is no clearing pass over the RAM.
// A result waits in the output register while the receiver stalls; the
// block then holds the next request's result and does not accept more.
module key_hold_state_tracker_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_opcode,
  input  logic [khst_pkg::CODE_W-1:0]    in_key_code,
  input  logic [khst_pkg::TIME_W-1:0]    in_elapsed_time,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_handled,
  output logic                           out_is_down,
  output logic                           out_is_up,
  output logic                           out_is_held,
  input  logic                           cfg_we,
  input  logic [khst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [khst_pkg::TIME_W-1:0]    cfg_wdata
);

  khst_pkg::ctrl_cmd_t cmd;
  khst_pkg::dp_sts_t   sts;

  khst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  khst_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_opcode       (in_opcode),
    .in_key_code     (in_key_code),
    .in_elapsed_time (in_elapsed_time),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_handled     (out_handled),
    .out_is_down     (out_is_down),
    .out_is_up       (out_is_up),
    .out_is_held     (out_is_held),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

/* rtl/khst_checker.sv */
`include "key_hold_state_tracker_core_macros.svh"

module khst_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_handled,
  input logic out_is_down,
  input logic out_is_up,
  input logic out_is_held
);

  // A key is either down or up, never both or neither.
  `KHST_ASSERT_SAME(a_down_xor_up, clk, rst_n, out_valid, out_is_down != out_is_up)
  // A held key is always reported as down.
  `KHST_ASSERT_SAME(a_held_is_down, clk, rst_n, out_valid && out_is_held, out_is_down)
  // Only one request is worked on at a time.
  `KHST_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  // A stalled result stays valid and holds its handled, down and held flags.
  `KHST_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_handled) && $stable(out_is_down) && $stable(out_is_held))

endmodule

bind key_hold_state_tracker_core khst_checker u_khst_checker (.*);

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  typedef logic [khst_pkg::TIME_W-1:0] tval_t;
  typedef logic [khst_pkg::CODE_W-1:0] kcode_t;

  typedef struct packed {
    logic handled;
    logic is_down;
    logic is_up;
    logic is_held;
  } key_flags_t;

  class key_flag_scoreboard;
    khst_pkg::key_status_t status[khst_pkg::NUM_KEYS];
    tval_t hold_time[khst_pkg::NUM_KEYS];
    tval_t tick_sum;
    tval_t period;
    tval_t threshold;
    key_flags_t flags_due[$];
    int errors;

    function new();
      foreach (status[i]) begin
        status[i] = khst_pkg::KS_UP;
        hold_time[i] = '0;
      end
      tick_sum = '0;
      period = '0;
      threshold = '0;
      errors = 0;
    endfunction

    function tval_t sat_add(tval_t a, tval_t b);
      logic [khst_pkg::TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[khst_pkg::TIME_W] ? {khst_pkg::TIME_W{1'b1}} : s[khst_pkg::TIME_W-1:0];
    endfunction

    function void write_reg(logic [khst_pkg::CFG_IDX_W-1:0] idx, tval_t value);
      if (idx == khst_pkg::CFG_UPDATE_PERIOD) period = value;
      else threshold = value;
    endfunction

    function void note_request(khst_pkg::opcode_t op, kcode_t key, tval_t dt);
      key_flags_t f;
      case (op)
        khst_pkg::OP_DOWN: status[key] = khst_pkg::KS_DOWN;
        khst_pkg::OP_UP: begin
          status[key] = khst_pkg::KS_UP;
          hold_time[key] = '0;
        end
        khst_pkg::OP_TICK: begin
          tick_sum = sat_add(tick_sum, dt);
          if (tick_sum > period) begin
            foreach (status[i]) begin
              if (status[i] == khst_pkg::KS_DOWN) begin
                hold_time[i] = sat_add(hold_time[i], dt);
                if (hold_time[i] > threshold) status[i] = khst_pkg::KS_HELD;
              end
            end
            tick_sum = '0;
          end
        end
        default: ;
      endcase
      f.handled = (op == khst_pkg::OP_DOWN) || (op == khst_pkg::OP_UP);
      f.is_down = (status[key] == khst_pkg::KS_DOWN) || (status[key] == khst_pkg::KS_HELD);
      f.is_up = (status[key] == khst_pkg::KS_UP);
      f.is_held = (status[key] == khst_pkg::KS_HELD);
      flags_due.push_back(f);
    endfunction

    function void check_flags(key_flags_t got);
      key_flags_t want;
      string names[4];
      names = '{"is_held", "is_up", "is_down", "handled"};
      if (flags_due.size() == 0) begin
        $display("%0t: result with no request outstanding, got %b", $time, got);
        errors++;
        return;
      end
      want = flags_due.pop_front();
      for (int i = 3; i >= 0; i--) begin
        if (want[i] !== got[i]) begin
          $display("%0t: %s expected %0b actual %0b", $time, names[i], want[i], got[i]);
          errors++;
        end
      end
    endfunction

    function int pending();
      return flags_due.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_opcode;
  kcode_t in_key_code;
  tval_t in_elapsed_time;
  logic out_valid;
  logic out_ready;
  logic out_handled;
  logic out_is_down;
  logic out_is_up;
  logic out_is_held;
  logic cfg_we;
  logic [khst_pkg::CFG_IDX_W-1:0] cfg_index;
  tval_t cfg_wdata;

  key_flag_scoreboard sb;
  bit steady;
  int stall_reqs;

  key_hold_state_tracker_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_opcode(in_opcode),
    .in_key_code(in_key_code),
    .in_elapsed_time(in_elapsed_time),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_handled(out_handled),
    .out_is_down(out_is_down),
    .out_is_up(out_is_up),
    .out_is_held(out_is_held),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_run();
    int n = 0;
    if (!steady) begin
      while ($urandom_range(99) < 38) n++;
    end
    return n;
  endfunction

  task automatic send_req(khst_pkg::opcode_t op, kcode_t key, tval_t dt);
    int gap;
    gap = idle_run();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_key_code <= key;
    in_elapsed_time <= dt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(op, key, dt);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_config(tval_t period, tval_t threshold);
    in_valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= khst_pkg::CFG_UPDATE_PERIOD;
    cfg_wdata <= period;
    @(posedge clk);
    sb.write_reg(khst_pkg::CFG_UPDATE_PERIOD, period);
    cfg_index <= khst_pkg::CFG_HOLD_THRESHOLD;
    cfg_wdata <= threshold;
    @(posedge clk);
    sb.write_reg(khst_pkg::CFG_HOLD_THRESHOLD, threshold);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random(int pool[8], int small_dt);
    int r;
    khst_pkg::opcode_t op;
    kcode_t key;
    tval_t dt;
    r = $urandom_range(99);
    if (r < 25) op = khst_pkg::OP_DOWN;
    else if (r < 40) op = khst_pkg::OP_UP;
    else if (r < 75) op = khst_pkg::OP_TICK;
    else op = khst_pkg::OP_QUERY;
    key = khst_pkg::CODE_W'(($urandom_range(99) < 80) ? pool[3'($urandom_range(7))]
                                                       : $urandom_range(255));
    dt = khst_pkg::TIME_W'(($urandom_range(99) < 15) ? $urandom_range(65535)
                                                     : $urandom_range(small_dt));
    send_req(op, key, dt);
  endtask

  initial begin
    int hold_left;
    int stall_seen;
    hold_left = 0;
    stall_seen = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_flags({out_handled, out_is_down, out_is_up, out_is_held});
      if (stall_reqs != stall_seen && hold_left == 0) begin
        hold_left = 300;
        stall_seen = stall_reqs;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 38);
      end
    end
  end

  initial begin
    int pool[8];
    tval_t period;
    tval_t threshold;
    sb = new();
    steady = 1'b0;
    stall_reqs = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_opcode <= khst_pkg::OP_QUERY;
    in_key_code <= '0;
    in_elapsed_time <= '0;
    cfg_we <= 1'b0;
    cfg_index <= khst_pkg::CFG_UPDATE_PERIOD;
    cfg_wdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_config(16'd0, 16'd3);
    send_req(khst_pkg::OP_QUERY, 8'd0, 16'd0);
    send_req(khst_pkg::OP_DOWN, 8'd0, 16'd0);
    send_req(khst_pkg::OP_DOWN, 8'd255, 16'hFFFF);
    send_req(khst_pkg::OP_TICK, 8'd0, 16'd0);
    send_req(khst_pkg::OP_TICK, 8'd255, 16'd2);
    send_req(khst_pkg::OP_TICK, 8'd0, 16'd2);
    send_req(khst_pkg::OP_DOWN, 8'd0, 16'd0);
    send_req(khst_pkg::OP_TICK, 8'd0, 16'd1);
    send_req(khst_pkg::OP_QUERY, 8'd255, 16'd0);
    send_req(khst_pkg::OP_UP, 8'd255, 16'd0);
    send_req(khst_pkg::OP_UP, 8'd0, 16'd0);
    send_req(khst_pkg::OP_DOWN, 8'd0, 16'd0);
    send_req(khst_pkg::OP_QUERY, 8'd128, 16'd0);
    wait_drain();

    // Accumulator saturates and never exceeds the largest period.
    set_config(16'hFFFF, 16'hFFFF);
    send_req(khst_pkg::OP_DOWN, 8'd7, 16'd0);
    send_req(khst_pkg::OP_TICK, 8'd7, 16'hFFFF);
    send_req(khst_pkg::OP_TICK, 8'd7, 16'hFFFF);
    send_req(khst_pkg::OP_QUERY, 8'd7, 16'd0);
    wait_drain();

    // The timer saturates at the largest threshold without passing it, then a lower one makes the key held.
    set_config(16'd0, 16'hFFFF);
    send_req(khst_pkg::OP_TICK, 8'd7, 16'hFFFF);
    send_req(khst_pkg::OP_TICK, 8'd7, 16'hFFFF);
    wait_drain();
    set_config(16'd0, 16'hFFFE);
    send_req(khst_pkg::OP_TICK, 8'd7, 16'd1);
    send_req(khst_pkg::OP_QUERY, 8'd7, 16'd0);
    send_req(khst_pkg::OP_UP, 8'd7, 16'd0);
    wait_drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          period = '0;
          threshold = '0;
        end
        1: begin
          period = khst_pkg::TIME_W'($urandom_range(40, 1));
          threshold = khst_pkg::TIME_W'($urandom_range(600, 50));
        end
        2: begin
          period = khst_pkg::TIME_W'($urandom_range(500, 100));
          threshold = khst_pkg::TIME_W'($urandom_range(2000, 200));
        end
        3: begin
          period = '0;
          threshold = 16'hFFFF;
        end
        4: begin
          period = khst_pkg::TIME_W'($urandom_range(1000));
          threshold = khst_pkg::TIME_W'($urandom_range(65535));
        end
        default: begin
          period = 16'hFFFE;
          threshold = khst_pkg::TIME_W'($urandom_range(300));
        end
      endcase
      foreach (pool[i]) pool[i] = $urandom_range(255);
      steady = (phase == 1);
      set_config(period, threshold);
      for (int n = 0; n < 75; n++) begin
        if (phase == 2 && n == 20) stall_reqs++;
        if (phase == 3 && n == 40) begin
          wait_drain();
        end
        send_random(pool, 400);
      end
      wait_drain();
    end

    steady = 1'b0;
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
